FILE: design/bcq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcq_pkg;

	// Field widths of the command and result items.
	localparam int OP_W      = 3;
	localparam int BKT_W     = 3;
	localparam int PAY_W     = 32;
	localparam int OUT_BKT_W = 2;
	localparam int CNT_W     = 6;
	localparam int STAT_W    = 32;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
	localparam logic [OP_W-1:0] OP_FLUSH   = 3'd1;
	localparam logic [OP_W-1:0] OP_DISCARD = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
	localparam logic [OP_W-1:0] OP_START   = 3'd4;

	// Control of the per-bucket draw counter bank.
	typedef struct packed {
		logic             clr;
		logic             inc;
		logic [BKT_W-1:0] idx;
	} draw_ctl_t;

endpackage

`default_nettype wire

FILE: design/bcq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bcq_in_if;
	logic                       valid;
	logic                       ready;
	logic [bcq_pkg::OP_W-1:0]   operation;
	logic [bcq_pkg::BKT_W-1:0]  bucket;
	logic [bcq_pkg::PAY_W-1:0]  payload;
	logic [bcq_pkg::BKT_W-1:0]  query_bucket;

	modport source (output valid, operation, bucket, payload, query_bucket, input ready);
	modport sink (input valid, operation, bucket, payload, query_bucket, output ready);
endinterface

`default_nettype wire

FILE: design/bcq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bcq_out_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic                          command_valid;
	logic [bcq_pkg::OUT_BKT_W-1:0] out_bucket;
	logic [bcq_pkg::PAY_W-1:0]     out_payload;
	logic                          last;
	logic [bcq_pkg::CNT_W-1:0]     queue_count;
	logic [bcq_pkg::CNT_W-1:0]     peak_count;
	logic [bcq_pkg::STAT_W-1:0]    overflow_count;
	logic [bcq_pkg::STAT_W-1:0]    draws;

	modport source (output valid, ok, command_valid, out_bucket, out_payload, last,
		queue_count, peak_count, overflow_count, draws, input ready);
	modport sink (input valid, ok, command_valid, out_bucket, out_payload, last,
		queue_count, peak_count, overflow_count, draws, output ready);
endinterface

`default_nettype wire

FILE: design/bucketed_command_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bucketed command queue. Commands enter on cmd and every result item leaves on result
// through an output register; a new item is taken once that register is empty or its
// result leaves in the same cycle.
// Enqueue, discard, stop, start and refused or empty flushes each give one result. A flush
// of a running queue holding N commands scans the store once per bucket, reading each entry
// visited (S_RD) and then comparing its bucket (S_CHK), paced by the single read port of
// the store and the one shared bucket compare; it gives N results, the last one marked, and
// cmd is not ready until it ends. Every result reports the statistics as they stand once the
// whole operation is done.
module bucketed_command_queue_unit #(
	parameter int CAPACITY     = 32,
	parameter int BUCKETS      = 4,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire       clk,
	input  wire       arst_n,
	bcq_in_if.sink    cmd,
	bcq_out_if.source result
);

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
	localparam int EW = PW + BW;

	typedef enum logic [1:0] {S_IDLE, S_RD, S_CHK} state_t;

	state_t                     state_q;
	logic [FW-1:0]              fill_q;
	logic [FW-1:0]              peak_q;
	logic [31:0]                ovf_q;
	logic                       en_q;
	logic [FW-1:0]              held_q [BUCKETS];
	logic [BW-1:0]              b_q;
	logic [AW-1:0]              idx_q;
	logic [FW-1:0]              emit_q;
	logic [31:0]                draws_rep_q;

	logic                       res_valid_q;
	logic                       res_ok_q;
	logic                       res_cmd_q;
	logic [1:0]                 res_bkt_q;
	logic [31:0]                res_pay_q;
	logic                       res_last_q;
	logic [5:0]                 res_qcnt_q;
	logic [5:0]                 res_peak_q;
	logic [31:0]                res_ovf_q;
	logic [31:0]                res_draws_q;

	logic                       cmd_fire;
	logic                       out_free;
	logic                       res_load;
	logic                       qb_ok;
	logic                       bkt_ok;
	logic                       enq_ok;
	logic                       flush_go;
	logic [FW-1:0]              fill_nx;
	logic [FW-1:0]              peak_nx;
	logic [31:0]                ovf_nx;
	logic                       en_nx;
	logic                       ok_nx;
	logic                       clr_held;
	logic                       enq_we;
	logic [31:0]                draws_nx;
	logic [31:0]                q_total;
	logic [FW-1:0]              held_sel;
	bcq_pkg::draw_ctl_t         dctl;
	logic [EW-1:0]              rd_data;
	logic [BW-1:0]              rd_bkt;
	logic [PW-1:0]              rd_pay;
	logic                       match;
	logic                       is_last;
	logic                       idx_end;
	logic                       emit;

	// Handshake.
	assign out_free  = !res_valid_q || result.ready;
	assign cmd.ready = (state_q == S_IDLE) && out_free;
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Admission checks for the item on cmd.
	assign qb_ok    = 4'(cmd.query_bucket) < 4'(BUCKETS);
	assign bkt_ok   = 4'(cmd.bucket) < 4'(BUCKETS);
	assign enq_ok   = en_q && bkt_ok && (fill_q < FW'(CAPACITY));
	assign flush_go = (cmd.operation == bcq_pkg::OP_FLUSH) && en_q && (fill_q != '0);
	assign held_sel = qb_ok ? held_q[cmd.query_bucket[BW-1:0]] : '0;

	// Scan compare against the bucket being drained.
	assign rd_bkt  = rd_data[EW-1:PW];
	assign rd_pay  = rd_data[PW-1:0];
	assign match   = (rd_bkt == b_q);
	assign is_last = (emit_q == fill_q - FW'(1));
	assign idx_end = (idx_q == AW'(fill_q - FW'(1)));
	assign emit    = (state_q == S_CHK) && match && out_free;

	// The result register takes a new item on a one-result operation or a drained command.
	assign res_load = ((state_q == S_IDLE) && cmd_fire && !flush_go) || emit;

	// Next statistics for one-result operations, and draw counter control.
	always_comb begin
		fill_nx  = fill_q;
		peak_nx  = peak_q;
		ovf_nx   = ovf_q;
		en_nx    = en_q;
		ok_nx    = 1'b1;
		clr_held = 1'b0;
		enq_we   = 1'b0;
		draws_nx = q_total;
		dctl     = '0;
		unique case (cmd.operation)
			bcq_pkg::OP_ENQUEUE: begin
				if (enq_ok) begin
					fill_nx = fill_q + FW'(1);
					enq_we  = cmd_fire;
					if (fill_nx > peak_q) begin
						peak_nx = fill_nx;
					end
				end else begin
					ovf_nx = ovf_q + 32'd1;
					ok_nx  = 1'b0;
				end
			end
			bcq_pkg::OP_FLUSH: begin
				ok_nx = en_q;
			end
			bcq_pkg::OP_DISCARD: begin
				fill_nx  = '0;
				clr_held = 1'b1;
			end
			bcq_pkg::OP_STOP: begin
				fill_nx  = '0;
				en_nx    = 1'b0;
				clr_held = 1'b1;
			end
			bcq_pkg::OP_START: begin
				fill_nx  = '0;
				peak_nx  = '0;
				ovf_nx   = '0;
				en_nx    = 1'b1;
				clr_held = 1'b1;
				draws_nx = '0;
				dctl.clr = cmd_fire;
			end
			default: begin
				ok_nx = 1'b0;
			end
		endcase
		if (emit) begin
			dctl.inc = 1'b1;
			dctl.idx = bcq_pkg::BKT_W'(b_q);
		end
	end

	bcq_store #(
		.DEPTH(CAPACITY),
		.WIDTH(EW)
	) u_store (
		.clk  (clk),
		.we   (enq_we),
		.waddr(fill_q[AW-1:0]),
		.wdata({cmd.bucket[BW-1:0], cmd.payload[PW-1:0]}),
		.re   (state_q == S_RD),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	bcq_draws #(
		.BUCKETS(BUCKETS)
	) u_draws (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (dctl),
		.query (cmd.query_bucket),
		.total (q_total)
	);

	// Sequencer, queue state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			peak_q      <= '0;
			ovf_q       <= '0;
			en_q        <= 1'b0;
			held_q      <= '{default: '0};
			b_q         <= '0;
			idx_q       <= '0;
			emit_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire && flush_go) begin
						state_q     <= S_RD;
						b_q         <= '0;
						idx_q       <= '0;
						emit_q      <= '0;
						draws_rep_q <= q_total + 32'(held_sel);
					end else if (cmd_fire) begin
						fill_q <= fill_nx;
						peak_q <= peak_nx;
						ovf_q  <= ovf_nx;
						en_q   <= en_nx;
						if (clr_held) begin
							held_q <= '{default: '0};
						end else if (enq_we) begin
							held_q[cmd.bucket[BW-1:0]] <=
								held_q[cmd.bucket[BW-1:0]] + FW'(1);
						end
						res_ok_q    <= ok_nx;
						res_cmd_q   <= 1'b0;
						res_bkt_q   <= '0;
						res_pay_q   <= '0;
						res_last_q  <= 1'b1;
						res_qcnt_q  <= 6'(fill_nx);
						res_peak_q  <= 6'(peak_nx);
						res_ovf_q   <= ovf_nx;
						res_draws_q <= draws_nx;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!match || out_free) begin
						if (match) begin
							res_ok_q    <= 1'b1;
							res_cmd_q   <= 1'b1;
							res_bkt_q   <= 2'(b_q);
							res_pay_q   <= 32'(rd_pay);
							res_last_q  <= is_last;
							res_qcnt_q  <= '0;
							res_peak_q  <= 6'(peak_q);
							res_ovf_q   <= ovf_q;
							res_draws_q <= draws_rep_q;
							emit_q      <= emit_q + FW'(1);
						end
						if (match && is_last) begin
							state_q <= S_IDLE;
							fill_q  <= '0;
							held_q  <= '{default: '0};
						end else begin
							state_q <= S_RD;
							if (idx_end) begin
								idx_q <= '0;
								b_q   <= b_q + BW'(1);
							end else begin
								idx_q <= idx_q + AW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result outputs.
	assign result.valid          = res_valid_q;
	assign result.ok             = res_ok_q;
	assign result.command_valid  = res_cmd_q;
	assign result.out_bucket     = res_bkt_q;
	assign result.out_payload    = res_pay_q;
	assign result.last           = res_last_q;
	assign result.queue_count    = res_qcnt_q;
	assign result.peak_count     = res_peak_q;
	assign result.overflow_count = res_ovf_q;
	assign result.draws          = res_draws_q;

	// Checks on the queue bookkeeping and the flush sequencer.
	a_peak_covers_fill: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= fill_q)
		else $error("peak level below fill level");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CAPACITY))
		else $error("fill level beyond capacity");

	a_emit_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (emit_q < fill_q))
		else $error("flush emitted more commands than held");

	a_flush_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && flush_go) |=> (state_q == S_RD))
		else $error("flush of a running queue did not start its scan");

	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_last) |=> (state_q == S_IDLE && fill_q == '0))
		else $error("queue not empty after the last drained command");

endmodule

`default_nettype wire

FILE: design/bcq_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Command store: one write port and one registered read port.
module bcq_store #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 34
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/bcq_draws.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-bucket draw totals with one shared incrementer.
module bcq_draws #(
	parameter int BUCKETS = 4
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire bcq_pkg::draw_ctl_t          ctl,
	input  wire [bcq_pkg::BKT_W-1:0]         query,
	output logic [bcq_pkg::STAT_W-1:0]       total
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	logic [bcq_pkg::STAT_W-1:0] totals_q [BUCKETS];
	logic [bcq_pkg::STAT_W-1:0] inc_val;
	logic [BW-1:0]              inc_idx;

	// The one incrementer serves whichever bucket is being drawn.
	assign inc_idx = ctl.idx[BW-1:0];
	assign inc_val = totals_q[inc_idx] + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			totals_q <= '{default: '0};
		end else if (ctl.clr) begin
			totals_q <= '{default: '0};
		end else if (ctl.inc) begin
			totals_q[inc_idx] <= inc_val;
		end
	end

	// Query read; an out-of-range bucket reads as zero.
	assign total = (4'(query) < 4'(BUCKETS)) ? totals_q[query[BW-1:0]] : '0;

endmodule

`default_nettype wire
